// File: hw/rtl/mpfq_pkg.sv
// Shared types and sizing constants for the multilevel priority FIFO queue.
// No dependencies; used by mpfq_ctrl, mpfq_dp and the top level.
`timescale 1ns / 1ps

package mpfq_pkg;

    // queue sizing
    localparam int NUM_LEVELS = 64;
    localparam int NUM_ELEMS  = 64;

    localparam int LVL_W   = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int ID_W    = (NUM_ELEMS > 1) ? $clog2(NUM_ELEMS) : 1;
    localparam int COUNT_W = $clog2(NUM_ELEMS + 1);

    // top-level search: groups of eight level bits
    localparam int GRP      = 8;
    localparam int GRP_W    = 3;
    localparam int NUM_GRPS = (NUM_LEVELS + GRP - 1) / GRP;
    localparam int PAD_W    = NUM_GRPS * GRP;

    // port field widths
    localparam int REQ_FW = 2;
    localparam int ID_FW  = 6;
    localparam int LVL_FW = 6;
    localparam int CNT_FW = 7;

    typedef enum logic [1:0] {
        REQ_PUSH   = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_POP    = 2'd2,
        REQ_UPDATE = 2'd3
    } t_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_POP_RD,
        ST_POP_CAP,
        ST_UNL_RD,
        ST_UNL_LV,
        ST_UNL_WR,
        ST_LNK_RD,
        ST_LNK_WR,
        ST_FND_GRP,
        ST_FND_TOP,
        ST_RESULT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_POP_RD,
        OP_POP_CAP,
        OP_UNL_RD,
        OP_UNL_LV,
        OP_UNL_WR,
        OP_LNK_RD,
        OP_LNK_WR,
        OP_FND_GRP,
        OP_FND_TOP
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   res_load;
    } t_dp_cmd;

    typedef struct packed {
        t_req req;
        logic err;
        logic empty;
        logic lvl_busy;
    } t_dp_sts;

endpackage

// File: hw/rtl/multilevel_priority_fifo_queue.sv
// Each request steps through single-port memory states: pop reads and captures the head,
// then unlinks; remove unlinks; update unlinks and relinks; push links; all then search for
// the top level. Refused requests and pop of an empty queue go straight to the result.
// One request at a time; the next beat is taken in the idle cycle after the result loads.
// Reset (i_rst_n, synchronous, active low) clears level bits, membership and count;
// pointer memories need no clearing, so the block is ready right after reset.
`timescale 1ns / 1ps

module multilevel_priority_fifo_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [mpfq_pkg::REQ_FW-1:0] i_req_type,
    input  logic [mpfq_pkg::ID_FW-1:0]  i_elem_id,
    input  logic [mpfq_pkg::LVL_FW-1:0] i_priority_req,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [mpfq_pkg::ID_FW-1:0]  o_popped_id,
    output logic                        o_popped_valid,
    output logic [mpfq_pkg::LVL_FW-1:0] o_top_level,
    output logic                        o_queue_empty,
    output logic [mpfq_pkg::CNT_FW-1:0] o_elem_count,
    output logic                        o_req_error
);

    mpfq_pkg::t_dp_cmd cmd;
    mpfq_pkg::t_dp_sts sts;

    mpfq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    mpfq_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_type     (i_req_type),
        .i_elem_id      (i_elem_id),
        .i_priority_req (i_priority_req),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_popped_id    (o_popped_id),
        .o_popped_valid (o_popped_valid),
        .o_top_level    (o_top_level),
        .o_queue_empty  (o_queue_empty),
        .o_elem_count   (o_elem_count),
        .o_req_error    (o_req_error)
    );

endmodule

// File: hw/rtl/mpfq_ctrl.sv
// Sequencer for the multilevel priority FIFO queue: walks each request
// through the pop, unlink, link and top-level search steps it needs. Depends on mpfq_pkg.
`timescale 1ns / 1ps

module mpfq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_ready,
    input  mpfq_pkg::t_dp_sts i_sts,
    output mpfq_pkg::t_dp_cmd o_cmd
);

    mpfq_pkg::t_state r_state;
    mpfq_pkg::t_state n_state;
    logic             r_out_valid;
    logic             res_load;

    assign res_load = (r_state == mpfq_pkg::ST_RESULT) && (!r_out_valid || i_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mpfq_pkg::ST_IDLE: begin
                if (i_valid) n_state = mpfq_pkg::ST_DECODE;
            end
            mpfq_pkg::ST_DECODE: begin
                if (i_sts.err) begin
                    n_state = mpfq_pkg::ST_RESULT;
                end else begin
                    unique case (i_sts.req)
                        mpfq_pkg::REQ_PUSH: n_state = mpfq_pkg::ST_LNK_RD;
                        mpfq_pkg::REQ_POP:
                            n_state = i_sts.empty ? mpfq_pkg::ST_RESULT : mpfq_pkg::ST_POP_RD;
                        default: n_state = mpfq_pkg::ST_UNL_RD;
                    endcase
                end
            end
            mpfq_pkg::ST_POP_RD:  n_state = mpfq_pkg::ST_POP_CAP;
            mpfq_pkg::ST_POP_CAP: n_state = mpfq_pkg::ST_UNL_RD;
            mpfq_pkg::ST_UNL_RD:  n_state = mpfq_pkg::ST_UNL_LV;
            mpfq_pkg::ST_UNL_LV:  n_state = mpfq_pkg::ST_UNL_WR;
            mpfq_pkg::ST_UNL_WR: begin
                n_state = (i_sts.req == mpfq_pkg::REQ_UPDATE) ? mpfq_pkg::ST_LNK_RD
                                                                : mpfq_pkg::ST_FND_GRP;
            end
            mpfq_pkg::ST_LNK_RD: begin
                n_state = i_sts.lvl_busy ? mpfq_pkg::ST_LNK_WR : mpfq_pkg::ST_FND_GRP;
            end
            mpfq_pkg::ST_LNK_WR:  n_state = mpfq_pkg::ST_FND_GRP;
            mpfq_pkg::ST_FND_GRP: n_state = mpfq_pkg::ST_FND_TOP;
            mpfq_pkg::ST_FND_TOP: n_state = mpfq_pkg::ST_RESULT;
            mpfq_pkg::ST_RESULT: begin
                if (res_load) n_state = mpfq_pkg::ST_IDLE;
            end
            default: n_state = mpfq_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op       = mpfq_pkg::OP_NONE;
        o_cmd.res_load = res_load;
        o_ready        = 1'b0;
        unique case (r_state)
            mpfq_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) o_cmd.op = mpfq_pkg::OP_ACCEPT;
            end
            mpfq_pkg::ST_POP_RD:  o_cmd.op = mpfq_pkg::OP_POP_RD;
            mpfq_pkg::ST_POP_CAP: o_cmd.op = mpfq_pkg::OP_POP_CAP;
            mpfq_pkg::ST_UNL_RD:  o_cmd.op = mpfq_pkg::OP_UNL_RD;
            mpfq_pkg::ST_UNL_LV:  o_cmd.op = mpfq_pkg::OP_UNL_LV;
            mpfq_pkg::ST_UNL_WR:  o_cmd.op = mpfq_pkg::OP_UNL_WR;
            mpfq_pkg::ST_LNK_RD:  o_cmd.op = mpfq_pkg::OP_LNK_RD;
            mpfq_pkg::ST_LNK_WR:  o_cmd.op = mpfq_pkg::OP_LNK_WR;
            mpfq_pkg::ST_FND_GRP: o_cmd.op = mpfq_pkg::OP_FND_GRP;
            mpfq_pkg::ST_FND_TOP: o_cmd.op = mpfq_pkg::OP_FND_TOP;
            default:              o_cmd.op = mpfq_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mpfq_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;

endmodule

// File: hw/rtl/mpfq_dp.sv
// Datapath of the multilevel priority FIFO queue: per-level head/tail memories,
// per-element link memories, membership bits, count and top-level search.
// Depends on mpfq_pkg; driven by mpfq_ctrl.
`timescale 1ns / 1ps

module mpfq_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [mpfq_pkg::REQ_FW-1:0]   i_req_type,
    input  logic [mpfq_pkg::ID_FW-1:0]    i_elem_id,
    input  logic [mpfq_pkg::LVL_FW-1:0]   i_priority_req,
    input  mpfq_pkg::t_dp_cmd             i_cmd,
    output mpfq_pkg::t_dp_sts             o_sts,
    output logic [mpfq_pkg::ID_FW-1:0]    o_popped_id,
    output logic                          o_popped_valid,
    output logic [mpfq_pkg::LVL_FW-1:0]   o_top_level,
    output logic                          o_queue_empty,
    output logic [mpfq_pkg::CNT_FW-1:0]   o_elem_count,
    output logic                          o_req_error
);

    // memories
    logic [mpfq_pkg::ID_W-1:0]  m_head [mpfq_pkg::NUM_LEVELS];
    logic [mpfq_pkg::ID_W-1:0]  m_tail [mpfq_pkg::NUM_LEVELS];
    logic [mpfq_pkg::ID_W-1:0]  m_next [mpfq_pkg::NUM_ELEMS];
    logic [mpfq_pkg::ID_W-1:0]  m_prev [mpfq_pkg::NUM_ELEMS];
    logic [mpfq_pkg::LVL_W-1:0] m_elv  [mpfq_pkg::NUM_ELEMS];

    logic [mpfq_pkg::ID_W-1:0]  r_head_q, r_tail_q, r_next_q, r_prev_q;
    logic [mpfq_pkg::LVL_W-1:0] r_elv_q;

    logic [mpfq_pkg::LVL_W-1:0] head_addr, tail_addr;
    logic [mpfq_pkg::ID_W-1:0]  next_addr, prev_addr, elv_addr;
    logic                       head_we, tail_we, next_we, prev_we, elv_we;
    logic [mpfq_pkg::ID_W-1:0]  head_wd, tail_wd, next_wd, prev_wd;
    logic [mpfq_pkg::LVL_W-1:0] elv_wd;

    // control state
    logic [mpfq_pkg::NUM_LEVELS-1:0] r_nonempty;
    logic [mpfq_pkg::NUM_ELEMS-1:0]  r_member;
    logic [mpfq_pkg::COUNT_W-1:0]    r_count;
    logic [mpfq_pkg::LVL_W-1:0]      r_top;
    logic                            r_empty;

    // request and working registers
    mpfq_pkg::t_req             r_req;
    logic [mpfq_pkg::ID_W-1:0]  r_elem;
    logic [mpfq_pkg::LVL_W-1:0] r_lvl;
    logic                       r_err;
    logic [mpfq_pkg::ID_W-1:0]  r_pid;
    logic                       r_pvalid;
    logic [mpfq_pkg::LVL_W-1:0] r_ulv;
    logic [mpfq_pkg::ID_W-1:0]  r_nx, r_pv;
    logic                       r_grp_any [mpfq_pkg::NUM_GRPS];
    logic [mpfq_pkg::GRP_W-1:0] r_grp_idx [mpfq_pkg::NUM_GRPS];

    // output registers
    logic [mpfq_pkg::ID_FW-1:0]  r_o_pid;
    logic                        r_o_pvalid;
    logic [mpfq_pkg::LVL_FW-1:0] r_o_top;
    logic                        r_o_empty;
    logic [mpfq_pkg::CNT_FW-1:0] r_o_count;
    logic                        r_o_err;

    // request decode
    logic                       id_ok, member_in, err_in;
    logic [mpfq_pkg::ID_W-1:0]  e_in;
    logic [mpfq_pkg::LVL_W-1:0] pr_sat;
    logic                       lvl_busy, is_head, is_tail;

    logic [mpfq_pkg::PAD_W-1:0] nz_pad;
    logic                       grp_any [mpfq_pkg::NUM_GRPS];
    logic [mpfq_pkg::GRP_W-1:0] grp_idx [mpfq_pkg::NUM_GRPS];
    logic [mpfq_pkg::LVL_W-1:0] top_c;
    logic                       any_c;

    assign id_ok  = int'(i_elem_id) < mpfq_pkg::NUM_ELEMS;
    assign e_in   = id_ok ? mpfq_pkg::ID_W'(i_elem_id) : '0;
    assign member_in = id_ok && r_member[e_in];
    assign pr_sat = (int'(i_priority_req) >= mpfq_pkg::NUM_LEVELS)
                  ? mpfq_pkg::LVL_W'(mpfq_pkg::NUM_LEVELS - 1)
                  : mpfq_pkg::LVL_W'(i_priority_req);

    always_comb begin
        unique case (mpfq_pkg::t_req'(i_req_type))
            mpfq_pkg::REQ_PUSH: err_in = !id_ok || member_in;
            mpfq_pkg::REQ_POP:  err_in = 1'b0;
            default:            err_in = !member_in;
        endcase
    end

    assign lvl_busy = r_nonempty[r_lvl];
    assign is_head  = (r_head_q == r_elem);
    assign is_tail  = (r_tail_q == r_elem);

    assign o_sts.req      = r_req;
    assign o_sts.err      = r_err;
    assign o_sts.empty    = r_empty;
    assign o_sts.lvl_busy = lvl_busy;

    // memory port steering
    always_comb begin
        head_addr = r_lvl;
        head_we   = 1'b0;
        head_wd   = r_elem;
        tail_addr = r_lvl;
        tail_we   = 1'b0;
        tail_wd   = r_elem;
        next_addr = r_elem;
        next_we   = 1'b0;
        next_wd   = r_elem;
        prev_addr = r_elem;
        prev_we   = 1'b0;
        prev_wd   = r_tail_q;
        elv_addr  = r_elem;
        elv_we    = 1'b0;
        elv_wd    = r_lvl;
        unique case (i_cmd.op)
            mpfq_pkg::OP_POP_RD: head_addr = r_top;
            mpfq_pkg::OP_UNL_LV: begin
                head_addr = r_elv_q;
                tail_addr = r_elv_q;
            end
            mpfq_pkg::OP_UNL_WR: begin
                // head only: advance head; tail only: back up tail;
                // middle: splice neighbors; sole element: level bit clears
                head_addr = r_ulv;
                head_we   = is_head && !is_tail;
                head_wd   = r_nx;
                tail_addr = r_ulv;
                tail_we   = is_tail && !is_head;
                tail_wd   = r_pv;
                next_addr = r_pv;
                next_we   = !is_head && !is_tail;
                next_wd   = r_nx;
                prev_addr = r_nx;
                prev_we   = !is_head && !is_tail;
                prev_wd   = r_pv;
            end
            mpfq_pkg::OP_LNK_RD: begin
                // empty level: element becomes head and tail now
                head_we = !lvl_busy;
                tail_we = !lvl_busy;
                elv_we  = !lvl_busy;
            end
            mpfq_pkg::OP_LNK_WR: begin
                tail_we   = 1'b1;
                next_addr = r_tail_q;
                next_we   = 1'b1;
                prev_we   = 1'b1;
                elv_we    = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (head_we) m_head[head_addr] <= head_wd;
        r_head_q <= m_head[head_addr];
    end

    always_ff @(posedge i_clk) begin
        if (tail_we) m_tail[tail_addr] <= tail_wd;
        r_tail_q <= m_tail[tail_addr];
    end

    always_ff @(posedge i_clk) begin
        if (next_we) m_next[next_addr] <= next_wd;
        r_next_q <= m_next[next_addr];
    end

    always_ff @(posedge i_clk) begin
        if (prev_we) m_prev[prev_addr] <= prev_wd;
        r_prev_q <= m_prev[prev_addr];
    end

    always_ff @(posedge i_clk) begin
        if (elv_we) m_elv[elv_addr] <= elv_wd;
        r_elv_q <= m_elv[elv_addr];
    end

    // top-level search, first stage: highest set bit within each group
    assign nz_pad = mpfq_pkg::PAD_W'(r_nonempty);

    always_comb begin
        for (int g = 0; g < mpfq_pkg::NUM_GRPS; g++) begin
            grp_any[g] = |nz_pad[g*mpfq_pkg::GRP +: mpfq_pkg::GRP];
            grp_idx[g] = '0;
            for (int b = 0; b < mpfq_pkg::GRP; b++) begin
                if (nz_pad[g*mpfq_pkg::GRP + b]) grp_idx[g] = mpfq_pkg::GRP_W'(b);
            end
        end
    end

    // second stage: highest non-empty group
    always_comb begin
        top_c = '0;
        any_c = 1'b0;
        for (int g = 0; g < mpfq_pkg::NUM_GRPS; g++) begin
            if (r_grp_any[g]) begin
                top_c = mpfq_pkg::LVL_W'(g * mpfq_pkg::GRP + int'(r_grp_idx[g]));
                any_c = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nonempty <= '0;
            r_member   <= '0;
            r_count    <= '0;
            r_top      <= '0;
            r_empty    <= 1'b1;
        end else begin
            unique case (i_cmd.op)
                mpfq_pkg::OP_UNL_WR: begin
                    r_member[r_elem] <= 1'b0;
                    if (r_count != '0) r_count <= r_count - mpfq_pkg::COUNT_W'(1);
                    if (is_head && is_tail) r_nonempty[r_ulv] <= 1'b0;
                end
                mpfq_pkg::OP_LNK_RD: begin
                    if (!lvl_busy) begin
                        r_nonempty[r_lvl] <= 1'b1;
                        r_member[r_elem]  <= 1'b1;
                        r_count           <= r_count + mpfq_pkg::COUNT_W'(1);
                    end
                end
                mpfq_pkg::OP_LNK_WR: begin
                    r_member[r_elem] <= 1'b1;
                    r_count          <= r_count + mpfq_pkg::COUNT_W'(1);
                end
                mpfq_pkg::OP_FND_TOP: begin
                    r_top   <= top_c;
                    r_empty <= !any_c;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            mpfq_pkg::OP_ACCEPT: begin
                r_req    <= mpfq_pkg::t_req'(i_req_type);
                r_elem   <= e_in;
                r_lvl    <= pr_sat;
                r_err    <= err_in;
                r_pid    <= '0;
                r_pvalid <= 1'b0;
            end
            mpfq_pkg::OP_POP_CAP: begin
                r_elem   <= r_head_q;
                r_pid    <= r_head_q;
                r_pvalid <= 1'b1;
            end
            mpfq_pkg::OP_UNL_LV: begin
                r_ulv <= r_elv_q;
                r_nx  <= r_next_q;
                r_pv  <= r_prev_q;
            end
            mpfq_pkg::OP_FND_GRP: begin
                r_grp_any <= grp_any;
                r_grp_idx <= grp_idx;
            end
            default: ;
        endcase
        if (i_cmd.res_load) begin
            r_o_pid    <= mpfq_pkg::ID_FW'(r_pid);
            r_o_pvalid <= r_pvalid;
            r_o_top    <= mpfq_pkg::LVL_FW'(r_top);
            r_o_empty  <= r_empty;
            r_o_count  <= mpfq_pkg::CNT_FW'(r_count);
            r_o_err    <= r_err;
        end
    end

    assign o_popped_id    = r_o_pid;
    assign o_popped_valid = r_o_pvalid;
    assign o_top_level    = r_o_top;
    assign o_queue_empty  = r_o_empty;
    assign o_elem_count   = r_o_count;
    assign o_req_error    = r_o_err;

`ifndef SYNTH
    a_count_matches_members: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_member) == int'(r_count))
        else $error("element count differs from membership bits");

    a_empty_matches_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.res_load |-> (r_empty == (r_nonempty == '0)))
        else $error("empty flag disagrees with level bits at result");

    a_empty_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.res_load |-> (r_empty == (r_count == '0)))
        else $error("empty flag disagrees with element count at result");

    a_unlink_member: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == mpfq_pkg::OP_UNL_WR) |-> r_member[r_elem])
        else $error("unlink of an element that is not queued");
`endif

endmodule
